// ===== hw/rtl/esu_pkg.sv =====
// Shared types, character codes and hex digit helper for the escape decoder.
`default_nettype none

package esu_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_UPPER_X   = 8'h58;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F   = 8'h46;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
   localparam logic [7:0] HEX_LETTER_OFS = 8'd10;

   // Escape phase, one-hot.
   typedef enum logic [3:0] {
      PH_PLAIN   = 4'b0001,
      PH_BSLASH  = 4'b0010,
      PH_HEX_HI  = 4'b0100,
      PH_HEX_LO  = 4'b1000
   } esu_phase_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_string;
   } esu_req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       has_byte;
      logic       end_mark;
   } esu_rsp_type;

   // Decoder outcome for one byte: next state plus the word to emit, if any.
   typedef struct packed {
      esu_phase_type phase;
      logic [3:0]    nibble;
      logic          emit;
      esu_rsp_type   rsp;
   } esu_dec_type;

   // Hex digit value; anything that is not a hex digit counts as zero.
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      begin
         v = 8'd0;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            v = c - CHAR_ZERO;
         end else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            v = c - CHAR_UPPER_A + HEX_LETTER_OFS;
         end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            v = c - CHAR_LOWER_A + HEX_LETTER_OFS;
         end
         hex_value = v[3:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/esu_decode.sv =====
// Combinational escape decoder: one byte plus current state in, next state and result out.
`default_nettype none

module esu_decode (
   input  esu_pkg::esu_phase_type phase,
   input  logic [3:0]             nibble,
   input  esu_pkg::esu_req_type   word,
   output esu_pkg::esu_dec_type   dec
);
   import esu_pkg::*;

   esu_phase_type phase_nxt;
   logic [3:0]    nibble_nxt;
   logic          have;
   logic [7:0]    val;
   logic          is_x;

   assign is_x = (word.char_in == CHAR_LOWER_X) || (word.char_in == CHAR_UPPER_X);

   always_comb begin
      phase_nxt  = phase;
      nibble_nxt = nibble;
      have       = 1'b0;
      val        = 8'd0;
      unique case (phase)
         PH_PLAIN: begin
            if (word.char_in == CHAR_BACKSLASH) begin
               phase_nxt = PH_BSLASH;
            end else begin
               have = 1'b1;
               val  = word.char_in;
            end
         end
         PH_BSLASH: begin
            if (is_x) begin
               phase_nxt = PH_HEX_HI;
            end else begin
               have      = 1'b1;
               val       = word.char_in;
               phase_nxt = PH_PLAIN;
            end
         end
         PH_HEX_HI: begin
            nibble_nxt = hex_value(word.char_in);
            phase_nxt  = PH_HEX_LO;
         end
         PH_HEX_LO: begin
            have      = 1'b1;
            val       = {nibble, hex_value(word.char_in)};
            phase_nxt = PH_PLAIN;
         end
         default: begin
            phase_nxt = PH_PLAIN;
         end
      endcase

      // last byte closes the string and drops any open escape
      if (word.end_of_string) begin
         phase_nxt  = PH_PLAIN;
         nibble_nxt = 4'd0;
      end
   end

   assign dec.phase        = phase_nxt;
   assign dec.nibble       = nibble_nxt;
   assign dec.emit         = have || word.end_of_string;
   assign dec.rsp.char_out = val;
   assign dec.rsp.has_byte = have;
   assign dec.rsp.end_mark = word.end_of_string;

endmodule

`default_nettype wire

// ===== hw/rtl/escaped_string_unescaper_top.sv =====
// Top level of the backslash hex-escape decoder: input register, decoder, result register.
`default_nettype none

//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+------------------------------------
//  req     | in        | req_valid / req_stall  | req_word: char_in, end_of_string
//  rsp     | out       | rsp_valid / rsp_stall  | rsp_word: char_out, has_byte, end_mark
//
//  One word per cycle while rsp_stall is low; words pass input then result register.
//  The escape state (phase, high nibble) is updated as a word moves from the
//  input register to the result register, so consecutive bytes flow back to back.
//  Bytes that open or continue an escape give no rsp word unless they end the string.
//  Synchronous active-high reset empties both registers and returns to plain text.
//  rsp_stall holds the result register; req_stall rises only when the input
//  register is full and cannot drain into the result register.

module escaped_string_unescaper_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  esu_pkg::esu_req_type req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output esu_pkg::esu_rsp_type rsp_word
);
   import esu_pkg::*;

   // input register
   logic          in_valid_ff, in_valid_in;
   esu_req_type   in_word_ff;

   // escape state
   esu_phase_type phase_ff, phase_in;
   logic [3:0]    nibble_ff, nibble_in;

   // result register
   logic          out_valid_ff, out_valid_in;
   esu_rsp_type   out_word_ff;

   esu_dec_type   dec;
   logic          out_free;   // result register can take a new word this cycle
   logic          advance;    // input word is decoded this cycle
   logic          load;       // new req word accepted

   esu_decode u_decode (
      .phase  (phase_ff),
      .nibble (nibble_ff),
      .word   (in_word_ff),
      .dec    (dec)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign load      = req_valid && !req_stall;

   assign in_valid_in  = load || (in_valid_ff && !advance);
   assign phase_in     = advance ? dec.phase : phase_ff;
   assign nibble_in    = advance ? dec.nibble : nibble_ff;
   assign out_valid_in = out_free ? (advance && dec.emit) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_PLAIN;
         nibble_ff    <= 4'd0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         nibble_ff    <= nibble_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (load) begin
         in_word_ff <= req_word;
      end
      if (advance && dec.emit) begin
         out_word_ff <= dec.rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // every word without a data byte must be the end-of-string word
   a_empty_is_end: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_word_ff.has_byte || out_word_ff.end_mark))
      else $error("rsp word with neither byte nor end mark");

   // an empty word carries a zero byte
   a_empty_is_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_word_ff.has_byte) |-> (out_word_ff.char_out == 8'd0))
      else $error("rsp word without byte has nonzero char_out");

   // the last byte of a string always produces a marked word and clears the state
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      (advance && in_word_ff.end_of_string) |=>
         (out_valid_ff && out_word_ff.end_mark && phase_ff == PH_PLAIN
          && nibble_ff == 4'd0))
      else $error("end of string not closed properly");

   // a decoded word always lands in the result register
   a_no_loss: assert property (@(posedge clock) disable iff (reset)
      (advance && dec.emit) |=> out_valid_ff)
      else $error("decoded word lost");

endmodule

`default_nettype wire

// ===== tb/esu_checker.sv =====
// Checker for the escape decoder: predicts each result word and compares it.
`timescale 1ns / 1ps

module esu_checker (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  esu_pkg::esu_req_type req_word,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  esu_pkg::esu_rsp_type rsp_word,
   output int                   fail_count,
   output int                   words_pending
);
   import esu_pkg::*;

   esu_phase_type esc_phase;
   logic [3:0]    hi_nibble;
   esu_rsp_type   decoded_q[$];
   int            fails;

   // Hex digit value; letters are case-folded, anything else counts as zero.
   function automatic logic [3:0] digit_value(input logic [7:0] c);
      logic [7:0] folded;
      begin
         folded = c | 8'h20;
         if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            digit_value = c[3:0];
         end else if (folded >= CHAR_LOWER_A && folded <= CHAR_LOWER_F) begin
            digit_value = folded[3:0] + 4'd9;
         end else begin
            digit_value = 4'd0;
         end
      end
   endfunction

   // Advance the escape state by one byte; queue a word when one is due.
   task automatic decode_byte(input esu_req_type w);
      esu_rsp_type r;
      begin
         r = '0;
         case (esc_phase)
            PH_PLAIN: begin
               if (w.char_in == CHAR_BACKSLASH) begin
                  esc_phase = PH_BSLASH;
               end else begin
                  r.has_byte = 1'b1;
                  r.char_out = w.char_in;
               end
            end
            PH_BSLASH: begin
               if (w.char_in == CHAR_LOWER_X || w.char_in == CHAR_UPPER_X) begin
                  esc_phase = PH_HEX_HI;
               end else begin
                  r.has_byte = 1'b1;
                  r.char_out = w.char_in;
                  esc_phase  = PH_PLAIN;
               end
            end
            PH_HEX_HI: begin
               hi_nibble = digit_value(w.char_in);
               esc_phase = PH_HEX_LO;
            end
            default: begin
               r.has_byte = 1'b1;
               r.char_out = {hi_nibble, digit_value(w.char_in)};
               esc_phase  = PH_PLAIN;
            end
         endcase
         if (w.end_of_string) begin
            esc_phase  = PH_PLAIN;
            hi_nibble  = 4'd0;
            r.end_mark = 1'b1;
         end
         if (r.has_byte || r.end_mark) begin
            decoded_q.push_back(r);
         end
      end
   endtask

   task automatic compare_word(input esu_rsp_type got);
      esu_rsp_type want;
      begin
         if (decoded_q.size() == 0) begin
            $error("rsp word %h with nothing expected", got);
            fails++;
         end else begin
            want = decoded_q.pop_front();
            if (got.char_out !== want.char_out) begin
               $error("char_out: expected %h, actual %h", want.char_out, got.char_out);
               fails++;
            end
            if (got.has_byte !== want.has_byte) begin
               $error("has_byte: expected %b, actual %b", want.has_byte, got.has_byte);
               fails++;
            end
            if (got.end_mark !== want.end_mark) begin
               $error("end_mark: expected %b, actual %b", want.end_mark, got.end_mark);
               fails++;
            end
         end
      end
   endtask

   initial begin
      fails         = 0;
      fail_count    = 0;
      words_pending = 0;
      esc_phase     = PH_PLAIN;
      hi_nibble     = 4'd0;
   end

   always @(posedge clock) begin
      if (reset) begin
         esc_phase = PH_PLAIN;
         hi_nibble = 4'd0;
         decoded_q.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            compare_word(rsp_word);
         end
         if (req_valid && !req_stall) begin
            decode_byte(req_word);
         end
      end
      fail_count    <= fails;
      words_pending <= decoded_q.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the escape decoder testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
   import esu_pkg::*;

   localparam int RANDOM_WORDS = 1000;
   localparam int IDLE_LIMIT   = 2000;   // cycles without any accepted word
   localparam int DRAIN_CYCLES = 20;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   esu_req_type req_word;
   logic        rsp_valid;
   logic        rsp_stall;
   esu_rsp_type rsp_word;

   int fail_count;
   int words_pending;
   int words_sent;
   int idle_cycles;
   bit req_calm;          // no gaps on the req side while set
   int rsp_calm_left;     // words left in a stall-free stretch on the rsp side

   escaped_string_unescaper_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   esu_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_word      (req_word),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_word      (rsp_word),
      .fail_count    (fail_count),
      .words_pending (words_pending)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Offer one req word after a random gap; return once it is taken.
   // Valid stays high across back-to-back words.
   task automatic send_word(input logic [7:0] ch, input logic last);
      int gap;
      begin
         gap = req_calm ? 0 : $urandom_range(0, 12);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid              <= 1'b1;
         req_word.char_in       <= ch;
         req_word.end_of_string <= last;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         words_sent++;
      end
   endtask

   // Any byte except a backslash, so it passes through as plain text.
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      begin
         b = 8'($urandom_range(0, 255));
         if (b == CHAR_BACKSLASH) b = 8'($urandom_range(0, 91));
         plain_byte = b;
      end
   endfunction

   // Valid hex digit, mixed case.
   function automatic logic [7:0] hex_digit();
      int n;
      begin
         n = $urandom_range(0, 21);
         if (n < 10) hex_digit = CHAR_ZERO + 8'(n);
         else if (n < 16) hex_digit = CHAR_LOWER_A + 8'(n - 10);
         else hex_digit = CHAR_UPPER_A + 8'(n - 16);
      end
   endfunction

   // Mostly non-hex, with the bytes just outside each digit range
   // weighted up.
   function automatic logic [7:0] odd_digit();
      int n;
      begin
         n = $urandom_range(0, 7);
         case (n)
            0: odd_digit = CHAR_ZERO - 8'd1;
            1: odd_digit = CHAR_NINE + 8'd1;
            2: odd_digit = CHAR_UPPER_A - 8'd1;
            3: odd_digit = CHAR_UPPER_F + 8'd1;
            4: odd_digit = CHAR_LOWER_A - 8'd1;
            5: odd_digit = CHAR_LOWER_F + 8'd1;
            default: odd_digit = 8'($urandom_range(0, 255));
         endcase
      end
   endfunction

   // Build one escaped string and send it with the end flag on its last byte.
   task automatic send_string();
      logic [7:0] text_q[$];
      logic [7:0] esc;
      int         units;
      int         pick;
      int         i;
      begin
         units = $urandom_range(1, 8);
         for (i = 0; i < units; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
               text_q.push_back(plain_byte());
            end else if (pick < 70) begin
               // well-formed hex escape
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back($urandom_range(0, 1) ? CHAR_LOWER_X : CHAR_UPPER_X);
               text_q.push_back(hex_digit());
               text_q.push_back(hex_digit());
            end else if (pick < 90) begin
               // backslash with a literal follower, the backslash itself included
               esc = 8'($urandom_range(0, 255));
               if (esc == CHAR_LOWER_X || esc == CHAR_UPPER_X) esc = CHAR_BACKSLASH;
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back(esc);
            end else begin
               // hex escape with a bad low digit; the high digit may be bad too
               text_q.push_back(CHAR_BACKSLASH);
               text_q.push_back(CHAR_LOWER_X);
               text_q.push_back($urandom_range(0, 1) ? odd_digit() : hex_digit());
               text_q.push_back(odd_digit());
            end
         end
         // sometimes end on an escape that never completes
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            text_q.push_back(CHAR_BACKSLASH);
         end else if (pick == 1) begin
            text_q.push_back(CHAR_BACKSLASH);
            text_q.push_back(CHAR_UPPER_X);
         end else if (pick == 2) begin
            text_q.push_back(CHAR_BACKSLASH);
            text_q.push_back(CHAR_LOWER_X);
            text_q.push_back(hex_digit());
         end
         for (i = 0; i < text_q.size(); i++) begin
            send_word(text_q[i], i == text_q.size() - 1);
         end
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_word    <= '0;
      words_sent  = 0;
      req_calm    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: plain bytes at both extremes
      send_word("A", 1'b1);
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b1);
      // hex escapes, lower and upper case; the first ends the string on its last digit
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_LOWER_X, 1'b0);
      send_word("4", 1'b0);
      send_word("f", 1'b1);
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_UPPER_X, 1'b0);
      send_word("A", 1'b0);
      send_word("0", 1'b0);
      // non-hex digits count as zero
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_LOWER_X, 1'b0);
      send_word("G", 1'b0);
      send_word(":", 1'b0);
      // literal escapes, escaped backslash included
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word("n", 1'b0);
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_BACKSLASH, 1'b0);
      // escapes cut short by the end of the string
      send_word(CHAR_BACKSLASH, 1'b1);
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_LOWER_X, 1'b1);
      send_word(CHAR_BACKSLASH, 1'b0);
      send_word(CHAR_LOWER_X, 1'b0);
      send_word("7", 1'b1);

      // random: mostly well-formed strings, some raw noise words
      while (words_sent < RANDOM_WORDS) begin
         req_calm = ($urandom_range(0, 7) == 0);
         if ($urandom_range(0, 99) < 85) begin
            send_string();
         end else begin
            send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
      end
      // close any open string so the last word yields a result
      send_word(plain_byte(), 1'b1);
      req_valid <= 1'b0;

      // let the checker see the last accept, then drain
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && words_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   // Rsp side: random stall before each word, with stall-free stretches.
   initial begin : rsp_drive
      int hold;
      rsp_stall     <= 1'b0;
      rsp_calm_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (rsp_calm_left > 0) begin
            hold = 0;
            rsp_calm_left--;
         end else begin
            hold = $urandom_range(0, 12);
            if ($urandom_range(0, 31) == 0) rsp_calm_left = $urandom_range(10, 60);
         end
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Watchdog: too long with no word moving on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial idle_cycles = 0;

endmodule
